FILE: rtl/rhie_chow_face_velocity_line_top_macros.svh
// Assertion macros for the face velocity line block
`ifndef RHIE_CHOW_FACE_VELOCITY_LINE_TOP_MACROS_SVH
`define RHIE_CHOW_FACE_VELOCITY_LINE_TOP_MACROS_SVH
// implication checked every clock outside reset
`define RCF_ASSERT_IMP(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);
// next-cycle implication checked every clock outside reset
`define RCF_ASSERT_NXT(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);
`endif

FILE: rtl/rcf_pkg.sv
// Shared types and constants of the face velocity line block
package rcf_pkg;
  localparam int MaxCells = 1024;
  localparam int FracBits = 16;
  localparam int IdxW = 11;
  localparam int DivW = 31 + FracBits;

  typedef struct packed {
    logic signed [31:0] cell_velocity;
    logic signed [31:0] cell_pressure;
    logic signed [31:0] diag_coeff;
    logic [30:0] face_width;
    logic last_cell;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] face_velocity;
    logic [IdxW-1:0] face_index;
    logic div_fault;
    logic last_face;
  } out_item_t;

  // classified cell handed from front to back
  typedef struct packed {
    logic signed [31:0] vel;
    logic signed [31:0] pres;
    logic signed [31:0] d;
    logic [IdxW-1:0] k;
    logic last;
    logic fault;
  } cell_t;

  localparam logic [0:0] RegInterpMode = 1'b0;
endpackage

FILE: rtl/rhie_chow_face_velocity_line_top.sv
// Top level of the Rhie-Chow face velocity line block
//  channel | dir | handshake            | payload
//  in      | in  | in_valid/in_ready    | in_data (in_item_t)
//  out     | out | out_valid/out_ready  | out_data (out_item_t)
//  cfg     | in  | APB psel/penable     | pwdata bit 0 = interp_mode
// A Rhie-Chow cell holds the front through accept, 47 radix-2 divider steps
// and one hand-off to the queue; a linear-mode cell or a non-positive coefficient
// skips the divider and goes from accept straight to the hand-off.
// The back runs a computed face through B_M1, B_M2, B_SUM and B_EMIT, a boundary
// face through B_SUM and B_EMIT, and takes the next cell once its last face is taken.
// Reset is synchronous, needs no clearing pass, and sets interp_mode to 1.
// Output stalls back up through the queue to in_ready.
module rhie_chow_face_velocity_line_top (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  rcf_pkg::in_item_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output rcf_pkg::out_item_t out_data,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  import rcf_pkg::*;
  logic mode;
  logic fq_valid, fq_ready, bq_valid, bq_ready;
  cell_t fq_data, bq_data;

  assign pready = 1'b1;
  assign prdata = (paddr[1:0] == 2'b00) ? {31'd0, mode} : 32'd0;
  // hold the mode register
  always_ff @(posedge clk) begin
    if (rst) mode <= 1'b1;
    else if (psel && penable && pwrite && paddr == 2'b00) mode <= pwdata[0];
  end

  rcf_front u_front (.clk, .rst, .mode, .in_valid, .in_ready, .in_data,
    .q_valid(fq_valid), .q_ready(fq_ready), .q_data(fq_data));
  rcf_queue u_queue (.clk, .rst, .wr_valid(fq_valid), .wr_ready(fq_ready),
    .wr_data(fq_data), .rd_valid(bq_valid), .rd_ready(bq_ready), .rd_data(bq_data));
  rcf_back u_back (.clk, .rst, .mode, .q_valid(bq_valid), .q_ready(bq_ready),
    .q_data(bq_data), .out_valid, .out_ready, .out_data);
endmodule

FILE: rtl/rcf_front.sv
// Front part: accepts cells, forms d with a radix-2 divider, tags the cell
module rcf_front (
  input  logic clk,
  input  logic rst,
  input  logic mode,
  input  logic in_valid,
  output logic in_ready,
  input  rcf_pkg::in_item_t in_data,
  output logic q_valid,
  input  logic q_ready,
  output rcf_pkg::cell_t q_data
);
  import rcf_pkg::*;
  typedef enum logic [1:0] {S_IDLE, S_DIV, S_OUT} state_t;
  state_t state;
  in_item_t item;
  logic [DivW-1:0] num;
  logic [31:0] den;
  logic [32:0] rem;
  logic [DivW-1:0] quo;
  logic [5:0] cnt;
  logic [IdxW-1:0] k;
  logic fault;
  logic use_div;
  logic [32:0] trial;
  logic signed [31:0] d_val;
  logic cell_fault;

  assign in_ready = (state == S_IDLE);
  assign q_valid = (state == S_OUT);
  assign trial = {rem[31:0], num[DivW-1]} - {1'b0, den};

  // run one quotient bit per cycle, then offer the cell
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      k <= '0;
      fault <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) begin
          item <= in_data;
          num <= {in_data.face_width, {FracBits{1'b0}}};
          den <= in_data.diag_coeff;
          rem <= '0;
          quo <= '0;
          cnt <= 6'(DivW);
          use_div <= mode && (in_data.diag_coeff > 0);
          d_val <= mode ? 32'sh7fffffff : 32'sd0;
          cell_fault <= fault || (mode && in_data.diag_coeff <= 0);
          fault <= fault || (mode && in_data.diag_coeff <= 0);
          state <= (mode && in_data.diag_coeff > 0) ? S_DIV : S_OUT;
        end
        S_DIV: begin
          if (!trial[32]) begin
            rem <= trial;
            quo <= {quo[DivW-2:0], 1'b1};
          end else begin
            rem <= {rem[31:0], num[DivW-1]};
            quo <= {quo[DivW-2:0], 1'b0};
          end
          num <= num << 1;
          cnt <= cnt - 6'd1;
          if (cnt == 6'd1) state <= S_OUT;
        end
        S_OUT: if (q_ready) begin
          state <= S_IDLE;
          if (q_data.last) begin
            k <= '0;
            fault <= 1'b0;
          end else k <= k + 1'b1;
        end
        default: state <= S_IDLE;
      endcase
      if (state == S_DIV && cnt == 6'd1 && use_div)
        d_val <= (|quo[DivW-2:30]) ? 32'sh7fffffff : {1'b0, quo[29:0], ~trial[32]};
    end
  end

  assign q_data.vel = item.cell_velocity;
  assign q_data.pres = item.cell_pressure;
  assign q_data.d = d_val;
  assign q_data.k = k;
  assign q_data.last = item.last_cell || (k >= IdxW'(MaxCells - 1));
  assign q_data.fault = cell_fault;
endmodule

FILE: rtl/rcf_back.sv
// Back part: keeps the cell window and emits face velocities one at a time
module rcf_back (
  input  logic clk,
  input  logic rst,
  input  logic mode,
  input  logic q_valid,
  output logic q_ready,
  input  rcf_pkg::cell_t q_data,
  output logic out_valid,
  input  logic out_ready,
  output rcf_pkg::out_item_t out_data
);
  import rcf_pkg::*;
  typedef enum logic [2:0] {B_IDLE, B_M1, B_M2, B_SUM, B_EMIT} state_t;
  state_t state;
  cell_t c;
  logic signed [31:0] vw0, vw1, dw0, dw1, pw0, pw1, pw2;
  logic [1:0] phase;   // 0 interior/first face, 1 face n-1, 2 closing face
  logic signed [31:0] ua, ub, da, db, pa2, pa, pb, pb1;
  logic signed [32:0] dab, dx1, dx2;
  logic signed [63:0] m0, m1, m2, m3;
  logic signed [67:0] sum;
  logic signed [67:0] res;
  logic zero_face, rc;

  assign q_ready = (state == B_IDLE) && !out_valid;

  // pick stencil operands for the face under work
  always_comb begin
    if (phase == 2'd0) begin
      ua = vw1; ub = vw0; da = dw1; db = dw0;
      pa2 = (c.k >= IdxW'(3)) ? pw2 : pw1;
      pa = pw1; pb = pw0; pb1 = c.pres;
    end else begin
      ua = vw0; ub = c.vel; da = dw0; db = c.d;
      pa2 = (c.k >= IdxW'(2)) ? pw1 : pw0;
      pa = pw0; pb = c.pres; pb1 = c.pres;
    end
  end

  assign res = rc ? (sum >>> 2) : ((68'(ua) + 68'(ub)) >>> 1);

  // sequence the faces of one cell
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      out_valid <= 1'b0;
      {vw0, vw1, dw0, dw1, pw0, pw1, pw2} <= '0;
    end else begin
      // raise valid on a new face, drop it once the face is taken
      if (state == B_EMIT && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        B_IDLE: if (q_valid && !out_valid) begin
          c <= q_data;
          if (q_data.k == '0) begin
            phase <= 2'd0; zero_face <= 1'b1;
            state <= B_SUM;
          end else if (q_data.k >= IdxW'(2)) begin
            phase <= 2'd0; zero_face <= 1'b0;
            state <= B_M1;
          end else begin
            phase <= 2'd1; zero_face <= 1'b0;
            state <= q_data.last ? B_M1 : B_IDLE;
          end
          if (q_data.k == IdxW'(1) && !q_data.last) begin
            vw1 <= vw0; vw0 <= q_data.vel; dw1 <= dw0; dw0 <= q_data.d;
            pw2 <= pw1; pw1 <= pw0; pw0 <= q_data.pres;
          end
        end
        B_M1: begin
          rc <= mode;
          dab <= 33'(pa) - 33'(pb);
          dx1 <= 33'(pa2) - 33'(pb);
          dx2 <= 33'(pa) - 33'(pb1);
          state <= B_M2;
        end
        B_M2: begin
          m0 <= 64'(da) * 64'(dab);
          m1 <= 64'(db) * 64'(dab);
          m2 <= 64'(da) * 64'(dx1);
          m3 <= 64'(db) * 64'(dx2);
          state <= B_SUM;
        end
        B_SUM: begin
          sum <= 68'sd2 * (68'(ua) + 68'(ub))
               + 68'sd2 * (68'(m0 >>> FracBits) + 68'(m1 >>> FracBits))
               - 68'(m2 >>> FracBits) - 68'(m3 >>> FracBits);
          if (zero_face) rc <= 1'b0;
          if (!zero_face && phase != 2'd2) rc <= mode;
          state <= B_EMIT;
        end
        B_EMIT: if (!out_valid || out_ready) begin
          out_data.div_fault <= c.fault;
          out_data.last_face <= (phase == 2'd2);
          out_data.face_index <= (phase == 2'd0) ? ((c.k == '0) ? '0 : c.k - 1'b1)
                                 : (phase == 2'd1) ? c.k : c.k + 1'b1;
          if (zero_face) out_data.face_velocity <= '0;
          else if (res > 68'sh7fffffff) out_data.face_velocity <= 32'sh7fffffff;
          else if (res < -68'sh80000000) out_data.face_velocity <= 32'sh80000000;
          else out_data.face_velocity <= res[31:0];
          if (phase == 2'd0 && c.last && c.k != '0) begin
            phase <= 2'd1; zero_face <= 1'b0; state <= B_M1;
          end else if (phase != 2'd2 && c.last) begin
            phase <= 2'd2; zero_face <= 1'b1; state <= B_SUM;
          end else begin
            state <= B_IDLE;
            if (c.last) {vw0, vw1, dw0, dw1, pw0, pw1, pw2} <= '0;
            else begin
              vw1 <= vw0; vw0 <= c.vel; dw1 <= dw0; dw0 <= c.d;
              pw2 <= pw1; pw1 <= pw0; pw0 <= c.pres;
            end
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end
endmodule

FILE: rtl/rcf_queue.sv
// Two-entry queue between front and back
module rcf_queue (
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  output logic wr_ready,
  input  rcf_pkg::cell_t wr_data,
  output logic rd_valid,
  input  logic rd_ready,
  output rcf_pkg::cell_t rd_data
);
  import rcf_pkg::*;
  cell_t mem [2];
  logic wp, rp;
  logic [1:0] cnt;
  assign wr_ready = (cnt != 2'd2);
  assign rd_valid = (cnt != 2'd0);
  assign rd_data = mem[rp];
  // advance pointers on each request
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= '0;
    end else begin
      if (wr_valid && wr_ready) begin
        mem[wp] <= wr_data; wp <= ~wp;
      end
      if (rd_valid && rd_ready) rp <= ~rp;
      cnt <= cnt + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
    end
  end
endmodule

FILE: rtl/rcf_checker.sv
// Port-level checker of the face velocity line block and its bind
`include "rhie_chow_face_velocity_line_top_macros.svh"
module rcf_checker (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input rcf_pkg::out_item_t out_data,
  input logic pready
);
  `RCF_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "a_out_hold")
  `RCF_ASSERT_IMP(a_last_zero, out_valid && out_data.last_face, out_data.face_velocity == 0, "a_last_zero")
  `RCF_ASSERT_IMP(a_pready, 1'b1, pready, "a_pready")
endmodule

bind rhie_chow_face_velocity_line_top rcf_checker u_chk (.clk, .rst, .out_valid,
  .out_ready, .out_data, .pready);

FILE: dv/tb_rhie_chow_face_velocity_line_top.sv
// Testbench for the Rhie-Chow face velocity line block: directed table, linear-mode lines, then random lines
module tb_rhie_chow_face_velocity_line_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rcf_pkg::*;

  localparam logic [1:0] AddrInterpMode = 2'd0;
  localparam logic [31:0] SatMax = 32'h7fffffff;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;
  logic psel;
  logic penable;
  logic pwrite;
  logic [1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  rhie_chow_face_velocity_line_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor state
  logic mode_q;
  logic signed [31:0] vel_hist [2];
  logic signed [31:0] dcoef_hist [2];
  logic signed [31:0] pres_hist [3];
  int unsigned cells_seen;
  logic fault_q;

  out_item_t faces_pending [$];
  int errors;
  longint cycles;
  logic stall_rx;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic signed [63:0] fl_shr(logic signed [63:0] x, int s);
    return x >>> s;
  endfunction

  function automatic logic signed [31:0] sat(logic signed [63:0] x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  function automatic logic signed [63:0] qprod(logic signed [31:0] d,
                                               logic signed [63:0] dp);
    logic signed [95:0] pr;
    pr = 96'(d) * 96'(dp);
    return 64'(pr >>> FracBits);
  endfunction

  function automatic logic signed [31:0] face_vel(
      logic signed [31:0] ua, logic signed [31:0] ub,
      logic signed [31:0] da, logic signed [31:0] db,
      logic signed [31:0] pa2, logic signed [31:0] pa,
      logic signed [31:0] pb, logic signed [31:0] pb1);
    logic signed [63:0] dab;
    logic signed [63:0] acc;
    if (!mode_q) return sat(fl_shr(64'(ua) + 64'(ub), 1));
    dab = 64'(pa) - 64'(pb);
    acc = 2 * (64'(ua) + 64'(ub)) + 2 * (qprod(da, dab) + qprod(db, dab))
        - qprod(da, 64'(pa2) - 64'(pb)) - qprod(db, 64'(pa) - 64'(pb1));
    return sat(fl_shr(acc, 2));
  endfunction

  function automatic out_item_t mk_face(logic signed [31:0] v, int unsigned idx,
                                        logic lf);
    out_item_t f;
    f.face_velocity = v;
    f.face_index = idx[IdxW-1:0];
    f.div_fault = fault_q;
    f.last_face = lf;
    return f;
  endfunction

  // advance the line model by one cell and queue its faces
  task automatic predict_cell(in_item_t c);
    logic signed [31:0] dq;
    logic [63:0] quo;
    logic signed [31:0] pa2;
    logic is_last;
    int unsigned k;
    k = cells_seen;
    is_last = c.last_cell || (k >= MaxCells - 1);
    dq = '0;
    if (mode_q) begin
      if (c.diag_coeff <= 0) begin
        dq = SatMax;
        fault_q = 1'b1;
      end else begin
        quo = ({33'd0, c.face_width} << FracBits) / 64'(c.diag_coeff);
        dq = (quo > 64'(SatMax)) ? SatMax : quo[31:0];
      end
    end
    if (k == 0) faces_pending.push_back(mk_face('0, 0, 1'b0));
    else if (k >= 2) begin
      pa2 = (k - 1 >= 2) ? pres_hist[2] : pres_hist[1];
      faces_pending.push_back(mk_face(face_vel(vel_hist[1], vel_hist[0],
        dcoef_hist[1], dcoef_hist[0], pa2, pres_hist[1], pres_hist[0],
        c.cell_pressure), k - 1, 1'b0));
    end
    if (is_last) begin
      if (k >= 1) begin
        pa2 = (k >= 2) ? pres_hist[1] : pres_hist[0];
        faces_pending.push_back(mk_face(face_vel(vel_hist[0], c.cell_velocity,
          dcoef_hist[0], dq, pa2, pres_hist[0], c.cell_pressure, c.cell_pressure),
          k, 1'b0));
      end
      faces_pending.push_back(mk_face('0, k + 1, 1'b1));
      vel_hist = '{default: '0};
      dcoef_hist = '{default: '0};
      pres_hist = '{default: '0};
      cells_seen = 0;
      fault_q = 1'b0;
    end else begin
      vel_hist[1] = vel_hist[0];
      vel_hist[0] = c.cell_velocity;
      dcoef_hist[1] = dcoef_hist[0];
      dcoef_hist[0] = dq;
      pres_hist[2] = pres_hist[1];
      pres_hist[1] = pres_hist[0];
      pres_hist[0] = c.cell_pressure;
      cells_seen = k + 1;
    end
  endtask

  // predict on each accepted request
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) predict_cell(in_data);
  end

  // compare each accepted face with the oldest expectation
  always @(posedge clk) begin
    out_item_t exp_f;
    if (!rst && out_valid && out_ready) begin
      if (faces_pending.size() == 0) begin
        $display("%0t: unexpected face %h", $time, out_data);
        errors++;
      end else begin
        exp_f = faces_pending.pop_front();
        if (out_data.face_velocity !== exp_f.face_velocity)
          $display("%0t: face_velocity exp %h got %h", $time,
                   exp_f.face_velocity, out_data.face_velocity);
        if (out_data.face_index !== exp_f.face_index)
          $display("%0t: face_index exp %0d got %0d", $time,
                   exp_f.face_index, out_data.face_index);
        if (out_data.div_fault !== exp_f.div_fault)
          $display("%0t: div_fault exp %b got %b", $time,
                   exp_f.div_fault, out_data.div_fault);
        if (out_data.last_face !== exp_f.last_face)
          $display("%0t: last_face exp %b got %b", $time,
                   exp_f.last_face, out_data.last_face);
        if (out_data !== exp_f) errors++;
      end
    end
  end

  // receiver stall pattern: calm and busy stretches
  always @(negedge clk) begin
    if (stall_rx) out_ready <= ($urandom_range(0, 3) != 0);
    else out_ready <= 1'b1;
    if ($urandom_range(0, 99) == 0) stall_rx <= ~stall_rx;
  end

  task automatic write_mode(logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= AddrInterpMode;
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    mode_q = val[0];
  endtask

  int unsigned burst_left;

  // close any open burst, then wait until every queued face is out plus the tail latency
  task automatic drain();
    if (burst_left != 0) begin
      in_valid <= 1'b0;
      burst_left = 0;
    end
    while (faces_pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // drive one request, honoring burst and gap pacing
  task automatic send_cell(in_item_t c);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = $urandom_range(1, 16);
    end
    in_valid <= 1'b1;
    in_data <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    if (burst_left == 0) in_valid <= 1'b0;
  endtask

  function automatic in_item_t mk_cell(logic [31:0] u, logic [31:0] p,
      logic [31:0] c, logic [30:0] w, logic lc);
    in_item_t x;
    x.cell_velocity = u;
    x.cell_pressure = p;
    x.diag_coeff = c;
    x.face_width = w;
    x.last_cell = lc;
    return x;
  endfunction

  function automatic logic [31:0] rnd_val();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 32'h0003ffff) - 32'h00020000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] rnd_coeff();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return $urandom() | 32'h80000000;
      2: return 32'h1;
      3: return 32'h7fffffff;
      default: return $urandom_range(32'h00001000, 32'h00400000);
    endcase
  endfunction

  in_item_t dir_tab [$];
  in_item_t cur_cell;
  int n;
  int len;

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b1;
    stall_rx = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    errors = 0;
    cycles = 0;
    burst_left = 0;
    mode_q = 1'b1;
    vel_hist = '{default: '0};
    dcoef_hist = '{default: '0};
    pres_hist = '{default: '0};
    cells_seen = 0;
    fault_q = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: single cell, two cells, extremes, non-positive coefficient
    dir_tab.push_back(mk_cell(32'h7fffffff, 32'h80000000, 32'h00010000, 31'h7fffffff, 1'b1));
    dir_tab.push_back(mk_cell(32'h80000000, 32'h7fffffff, 32'h00010000, 31'h00010000, 1'b0));
    dir_tab.push_back(mk_cell(32'h7fffffff, 32'h80000000, 32'h00000001, 31'h7fffffff, 1'b1));
    dir_tab.push_back(mk_cell(32'h00010000, 32'h00020000, 32'h00000000, 31'h0, 1'b0));
    dir_tab.push_back(mk_cell(32'h00030000, 32'hfffe0000, 32'h80000000, 31'h10000, 1'b0));
    dir_tab.push_back(mk_cell(32'hffff0000, 32'h00050000, 32'h00020000, 31'h10000, 1'b0));
    dir_tab.push_back(mk_cell(32'h00020000, 32'h00000000, 32'h00010000, 31'h20000, 1'b1));
    dir_tab.push_back(mk_cell(32'h80000000, 32'h80000000, 32'h7fffffff, 31'h0, 1'b0));
    dir_tab.push_back(mk_cell(32'h80000000, 32'h7fffffff, 32'h00008000, 31'h7fffffff, 1'b0));
    dir_tab.push_back(mk_cell(32'h80000000, 32'h80000000, 32'hffffffff, 31'h1, 1'b0));
    dir_tab.push_back(mk_cell(32'h7fffffff, 32'h7fffffff, 32'h00010000, 31'h10000, 1'b1));
    foreach (dir_tab[i]) send_cell(dir_tab[i]);
    drain();

    // linear mode lines, including a mode change inside a line
    write_mode(32'hfffffffe);
    foreach (dir_tab[i]) send_cell(dir_tab[i]);
    send_cell(mk_cell(32'h00010000, 32'h1, 32'h10000, 31'h10000, 1'b0));
    drain();
    write_mode(32'h1);
    send_cell(mk_cell(32'h00010000, 32'h2, 32'h10000, 31'h10000, 1'b1));
    drain();

    // random lines, mostly short, across several mode settings
    n = 0;
    while (n < 480) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
      for (int i = 0; i < len; i++) begin
        cur_cell = mk_cell(rnd_val(), rnd_val(), rnd_coeff(), 31'(rnd_val()),
                           (i == len - 1) || ($urandom_range(0, 49) == 0));
        send_cell(cur_cell);
        n++;
      end
      if ($urandom_range(0, 7) == 0) begin
        drain();
        write_mode($urandom());
      end
    end

    drain();
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
